@@ hdl/qte_pkg.sv @@
// shared types, constants and tables of the quaternion to euler converter
package qte_pkg;

   localparam int IN_W = 32;
   localparam int PROD_W = 37;
   localparam int SUM_W = 38;
   localparam int CW = 45;
   localparam int ZW = 33;
   localparam int ROLL_W = 32;
   localparam int PITCH_W = 31;

   localparam int CORDIC_ITERATIONS = 24;
   localparam int N_ITER = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
   localparam int NORM_STEPS = 6;
   localparam int NORM_BIT = 40;
   localparam int CORDIC_LAT = 1 + NORM_STEPS + N_ITER;
   localparam int SQRT_STEPS = 32;
   localparam int ROLL_DELAY = 1 + SQRT_STEPS;
   localparam int BACK_LAT = ROLL_DELAY + CORDIC_LAT;

   localparam int MID_DEPTH = 4;
   localparam int MID_AW = 2;
   localparam int MID_CW = 3;

   localparam logic signed [ZW-1:0] PI_Q29 = 33'sd1686629713;
   localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
   localparam logic signed [SUM_W-1:0] ONE_Q32 = 38'sh01_0000_0000;

   typedef struct packed {
      logic signed [SUM_W-1:0] sinr;
      logic signed [SUM_W-1:0] cosr;
      logic signed [SUM_W-1:0] siny;
      logic signed [SUM_W-1:0] cosy;
      logic signed [SUM_W-1:0] sine;
      logic                    clamped;
      logic                    sine_zero;
   } mid_item_type;

   typedef struct packed {
      logic [MID_CW-1:0] count;
      logic              full;
      logic              empty;
   } mid_status_type;

   // atan(2^-i) in q3.29
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0: v = 33'sd421657428;
         1: v = 33'sd248918915;
         2: v = 33'sd131521918;
         3: v = 33'sd66762579;
         4: v = 33'sd33510843;
         5: v = 33'sd16771758;
         6: v = 33'sd8387925;
         7: v = 33'sd4194219;
         8: v = 33'sd2097141;
         9: v = 33'sd1048575;
         10: v = 33'sd524288;
         11: v = 33'sd262144;
         12: v = 33'sd131072;
         13: v = 33'sd65536;
         14: v = 33'sd32768;
         15: v = 33'sd16384;
         16: v = 33'sd8192;
         17: v = 33'sd4096;
         18: v = 33'sd2048;
         19: v = 33'sd1024;
         20: v = 33'sd512;
         21: v = 33'sd256;
         22: v = 33'sd128;
         23: v = 33'sd64;
         24: v = 33'sd32;
         25: v = 33'sd16;
         26: v = 33'sd8;
         27: v = 33'sd4;
         28: v = 33'sd2;
         29: v = 33'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/qte_front.sv @@
// front end: component products, sums and pitch classification
module qte_front import qte_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic signed [IN_W-1:0] req_quat_w,
   input  logic signed [IN_W-1:0] req_quat_x,
   input  logic signed [IN_W-1:0] req_quat_y,
   input  logic signed [IN_W-1:0] req_quat_z,
   input  mid_status_type         mid_status,
   output logic                   mid_wr,
   output mid_item_type           mid_data
);

   // twice a product, floored to q.32
   function automatic logic signed [PROD_W-1:0] dprod(input logic signed [IN_W-1:0] a,
                                                      input logic signed [IN_W-1:0] b);
      logic signed [63:0] full;
      full = 64'(a) * 64'(b);
      return full[63:27];
   endfunction

   logic en;
   logic v1_ff, v2_ff;
   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   mid_item_type item_ff, item_in;

   assign en = !mid_status.full;
   assign req_full = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_push;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= dprod(req_quat_w, req_quat_x);
         yz_ff <= dprod(req_quat_y, req_quat_z);
         xx_ff <= dprod(req_quat_x, req_quat_x);
         yy_ff <= dprod(req_quat_y, req_quat_y);
         wz_ff <= dprod(req_quat_w, req_quat_z);
         xy_ff <= dprod(req_quat_x, req_quat_y);
         zz_ff <= dprod(req_quat_z, req_quat_z);
         wy_ff <= dprod(req_quat_w, req_quat_y);
         zx_ff <= dprod(req_quat_z, req_quat_x);
         item_ff <= item_in;
      end
   end

   always_comb begin
      item_in.sinr = SUM_W'(wx_ff) + SUM_W'(yz_ff);
      item_in.cosr = ONE_Q32 - SUM_W'(xx_ff) - SUM_W'(yy_ff);
      item_in.siny = SUM_W'(wz_ff) + SUM_W'(xy_ff);
      item_in.cosy = ONE_Q32 - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      item_in.sine = SUM_W'(wy_ff) - SUM_W'(zx_ff);
      item_in.clamped = (item_in.sine >= ONE_Q32) || (item_in.sine <= -ONE_Q32);
      item_in.sine_zero = (item_in.sine == '0);
   end

   assign mid_wr = en && v2_ff;
   assign mid_data = item_ff;

endmodule

@@ hdl/qte_mid_queue.sv @@
// short queue between front and back ends
module qte_mid_queue import qte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  mid_item_type   wr_data,
   input  logic           rd_en,
   output mid_item_type   rd_data,
   output mid_status_type status
);

   mid_item_type store_ff [MID_DEPTH];
   logic [MID_AW-1:0] wp_ff, rp_ff;
   logic [MID_CW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         count_ff <= count_ff + MID_CW'(wr_en) - MID_CW'(rd_en);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wp_ff] <= wr_data;
   end

   assign rd_data = store_ff[rp_ff];
   assign status.count = count_ff;
   assign status.full = (count_ff == MID_CW'(MID_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ hdl/qte_cordic.sv @@
// pipelined cordic atan2 in vectoring mode with normalization
module qte_cordic import qte_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SUM_W-1:0] in_y,
   input  logic signed [SUM_W-1:0] in_x,
   output logic signed [ZW-1:0]    angle
);

   localparam int LAST = NORM_STEPS + N_ITER;

   logic signed [CW-1:0] x_ff [0:LAST];
   logic signed [CW-1:0] y_ff [0:LAST];
   logic signed [ZW-1:0] z_ff [0:LAST];
   logic                 zero_ff [0:LAST];

   logic signed [CW-1:0] xe, ye;
   logic neg;

   assign xe = CW'(in_x);
   assign ye = CW'(in_y);
   assign neg = in_x[SUM_W-1];

   // left half plane folds over with a pi offset
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= neg ? -xe : xe;
         y_ff[0] <= neg ? -ye : ye;
         z_ff[0] <= neg ? (in_y[SUM_W-1] ? -PI_Q29 : PI_Q29) : '0;
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
      end
   end

   // binary search leading-one normalization
   for (genvar k = 1; k <= NORM_STEPS; k++) begin : g_norm
      localparam int SH = 1 << (NORM_STEPS - k);
      localparam logic signed [CW-1:0] LIM =
         {{(CW-1){1'b0}}, 1'b1} << (NORM_BIT + 1 - SH);
      logic signed [CW-1:0] ay;
      logic lift;
      assign ay = y_ff[k-1][CW-1] ? -y_ff[k-1] : y_ff[k-1];
      assign lift = (x_ff[k-1] < LIM) && (ay < LIM);
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k] <= lift ? (x_ff[k-1] <<< SH) : x_ff[k-1];
            y_ff[k] <= lift ? (y_ff[k-1] <<< SH) : y_ff[k-1];
            z_ff[k] <= z_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < N_ITER; i++) begin : g_iter
      localparam int K = NORM_STEPS + 1 + i;
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[K-1] >>> i;
      assign dy = x_ff[K-1] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[K-1][CW-1]) begin
               x_ff[K] <= x_ff[K-1] + dx;
               y_ff[K] <= y_ff[K-1] - dy;
               z_ff[K] <= z_ff[K-1] + atan_entry(i);
            end else begin
               x_ff[K] <= x_ff[K-1] - dx;
               y_ff[K] <= y_ff[K-1] + dy;
               z_ff[K] <= z_ff[K-1] - atan_entry(i);
            end
            zero_ff[K] <= zero_ff[K-1];
         end
      end
   end

   assign angle = zero_ff[LAST] ? '0 : z_ff[LAST];

endmodule

@@ hdl/qte_back.sv @@
// back end: pitch cosine by square root, three cordic units, result queue
module qte_back import qte_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mid_item_type              mid_data,
   input  mid_status_type            mid_status,
   output logic                      mid_rd,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ROLL_W-1:0]  rsp_yaw_angle,
   output logic                      rsp_pitch_clamped
);

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ROLL_W-1:0]  yaw;
      logic                      clamped;
   } rsp_item_type;

   logic en, take;
   logic [BACK_LAT-1:0] vld_ff, cl_ff, zr_ff, ng_ff;

   logic [63:0] sq_ff;
   logic [63:0] rv_ff [SQRT_STEPS];
   logic [63:0] rr_ff [SQRT_STEPS];
   logic signed [SUM_W-1:0] ps_ff [0:SQRT_STEPS];
   logic signed [SUM_W-1:0] sabs;

   logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;
   logic signed [ZW-1:0] rd_ff [ROLL_DELAY];
   logic signed [ZW-1:0] yd_ff [ROLL_DELAY];
   logic signed [SUM_W-1:0] pitch_x;

   rsp_item_type oq_ff [2];
   rsp_item_type res;
   logic wp_ff, rp_ff;
   logic [1:0] oq_count_ff;
   logic push, pop;

   // whole pipeline moves together while the result queue has room or a result is popped
   assign en = (oq_count_ff != 2'd2) || rsp_pop;
   assign take = en && !mid_status.empty;
   assign mid_rd = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[BACK_LAT-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cl_ff <= {cl_ff[BACK_LAT-2:0], mid_data.clamped};
         zr_ff <= {zr_ff[BACK_LAT-2:0], mid_data.sine_zero};
         ng_ff <= {ng_ff[BACK_LAT-2:0], mid_data.sine[SUM_W-1]};
      end
   end

   assign sabs = mid_data.sine[SUM_W-1] ? -mid_data.sine : mid_data.sine;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= 64'(sabs[31:0]) * 64'(sabs[31:0]);
         ps_ff[0] <= mid_data.sine;
      end
   end

   // digit-by-digit square root of one minus sine squared
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_prev, r_prev, trial;
      if (k == 0) begin : g_first
         assign v_prev = 64'd0 - sq_ff;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = rv_ff[k-1];
         assign r_prev = rr_ff[k-1];
      end
      assign trial = r_prev + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (v_prev >= trial) begin
               rv_ff[k] <= v_prev - trial;
               rr_ff[k] <= (r_prev >> 1) + BIT;
            end else begin
               rv_ff[k] <= v_prev;
               rr_ff[k] <= r_prev >> 1;
            end
            ps_ff[k+1] <= ps_ff[k];
         end
      end
   end

   assign pitch_x = $signed(SUM_W'(rr_ff[SQRT_STEPS-1][31:0]));

   qte_cordic u_roll (
      .clock (clock),
      .en    (en),
      .in_y  (mid_data.sinr),
      .in_x  (mid_data.cosr),
      .angle (roll_z)
   );

   qte_cordic u_yaw (
      .clock (clock),
      .en    (en),
      .in_y  (mid_data.siny),
      .in_x  (mid_data.cosy),
      .angle (yaw_z)
   );

   qte_cordic u_pitch (
      .clock (clock),
      .en    (en),
      .in_y  (ps_ff[SQRT_STEPS]),
      .in_x  (pitch_x),
      .angle (pitch_z)
   );

   // roll and yaw wait for the pitch path
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff[0] <= roll_z;
         yd_ff[0] <= yaw_z;
         for (int i = 1; i < ROLL_DELAY; i++) begin
            rd_ff[i] <= rd_ff[i-1];
            yd_ff[i] <= yd_ff[i-1];
         end
      end
   end

   function automatic logic signed [ZW-1:0] sat(input logic signed [ZW-1:0] v,
                                                input logic signed [ZW-1:0] lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   logic signed [ZW-1:0] roll_s, yaw_s, pitch_s;

   always_comb begin
      roll_s = sat(rd_ff[ROLL_DELAY-1], PI_Q29);
      yaw_s = sat(yd_ff[ROLL_DELAY-1], PI_Q29);
      if (cl_ff[BACK_LAT-1]) begin
         pitch_s = ng_ff[BACK_LAT-1] ? -HALF_PI_Q29 : HALF_PI_Q29;
      end else if (zr_ff[BACK_LAT-1]) begin
         pitch_s = '0;
      end else begin
         pitch_s = sat(pitch_z, HALF_PI_Q29);
      end
      res.roll = roll_s[ROLL_W-1:0];
      res.yaw = yaw_s[ROLL_W-1:0];
      res.pitch = pitch_s[PITCH_W-1:0];
      res.clamped = cl_ff[BACK_LAT-1];
   end

   assign push = en && vld_ff[BACK_LAT-1];
   assign pop = rsp_pop && (oq_count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         oq_count_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         oq_count_ff <= oq_count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) oq_ff[wp_ff] <= res;
   end

   assign rsp_empty = (oq_count_ff == 2'd0);
   assign rsp_roll_angle = oq_ff[rp_ff].roll;
   assign rsp_pitch_angle = oq_ff[rp_ff].pitch;
   assign rsp_yaw_angle = oq_ff[rp_ff].yaw;
   assign rsp_pitch_clamped = oq_ff[rp_ff].clamped;

endmodule

@@ hdl/quaternion_to_euler_top.sv @@
// top level of the quaternion to zyx euler angle converter
// throughput: one transaction per cycle unless stalled, set by the fully pipelined cordic and root stages
// a stalled result side freezes the back pipeline; the mid queue then fills and raises full
// reset: synchronous, active high; clears queue pointers and valid bits, data is not cleared
// after reset both queues are empty and full is low
module quaternion_to_euler_top import qte_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [IN_W-1:0]    req_quat_w,
   input  logic signed [IN_W-1:0]    req_quat_x,
   input  logic signed [IN_W-1:0]    req_quat_y,
   input  logic signed [IN_W-1:0]    req_quat_z,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ROLL_W-1:0]  rsp_yaw_angle,
   output logic                      rsp_pitch_clamped
);

   // front to queue
   logic           mid_wr;
   mid_item_type   mid_wr_data;
   // queue to back
   logic           mid_rd;
   mid_item_type   mid_rd_data;
   mid_status_type mid_status;

   // products and classification of each accepted transaction
   qte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .mid_status (mid_status),
      .mid_wr     (mid_wr),
      .mid_data   (mid_wr_data)
   );

   // decouples the front from back-end stalls
   qte_mid_queue u_mid (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_wr),
      .wr_data (mid_wr_data),
      .rd_en   (mid_rd),
      .rd_data (mid_rd_data),
      .status  (mid_status)
   );

   // square root, three atan2 units and the result queue
   qte_back u_back (
      .clock             (clock),
      .reset             (reset),
      .mid_data          (mid_rd_data),
      .mid_status        (mid_status),
      .mid_rd            (mid_rd),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_roll_angle    (rsp_roll_angle),
      .rsp_pitch_angle   (rsp_pitch_angle),
      .rsp_yaw_angle     (rsp_yaw_angle),
      .rsp_pitch_clamped (rsp_pitch_clamped)
   );

   // a full mid queue must hold off new transactions
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      mid_status.full |-> req_full)
      else $error("mid queue full but input not held off");

   // queue never reads while empty
   a_no_empty_read: assert property (@(posedge clock) disable iff (reset)
      mid_rd |-> !mid_status.empty)
      else $error("mid queue read while empty");

   // clamped pitch sits exactly at plus or minus pi/2
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pitch_clamped) |->
         (rsp_pitch_angle == PITCH_W'(HALF_PI_Q29)) ||
         (rsp_pitch_angle == PITCH_W'(-HALF_PI_Q29)))
      else $error("clamped pitch is not pi/2");

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
